// ===== hw/rtl/fpd_pkg.sv =====
// Package for the FSK period demodulator: widths, register indexes, reset
// values, command codes and the structs passed between the blocks.
// No dependencies.
package fpd_pkg;

  localparam int TIME_WIDTH      = 16;
  localparam int PERIOD_WIDTH    = TIME_WIDTH + 1;
  localparam int DATA_BITS       = 8;
  localparam int BIT_INDEX_WIDTH = 4;
  localparam int OUT_WIDTH       = 8;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COUNTER_MODULUS  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TONE_THRESHOLD   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_START_PERIOD = 2'd2;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] RST_COUNTER_MODULUS  = 16'd50000;
  localparam logic [CFG_WIDTH-1:0] RST_TONE_THRESHOLD   = 16'd15500;
  localparam logic [CFG_WIDTH-1:0] RST_MIN_START_PERIOD = 16'd5000;

  // Item commands
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [TIME_WIDTH-1:0] capture_time;
  } fpd_item_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] counter_modulus;
    logic [TIME_WIDTH-1:0] tone_threshold;
    logic [TIME_WIDTH-1:0] min_start_period;
  } fpd_cfg_t;

  // period_next: period of the capture being processed now
  // last_period: stored period of the most recent capture
  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] period_next;
    logic [PERIOD_WIDTH-1:0] last_period;
  } fpd_period_t;

  typedef struct packed {
    logic                 valid;
    logic [OUT_WIDTH-1:0] data;
  } fpd_result_t;

endpackage

// ===== hw/rtl/fpd_period.sv =====
// Period measurement between successive captures, wrapping at the modulus.
// Depends on fpd_pkg.
module fpd_period (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           capture,
  input  logic [fpd_pkg::TIME_WIDTH-1:0] capture_time,
  input  logic [fpd_pkg::TIME_WIDTH-1:0] counter_modulus,
  output fpd_pkg::fpd_period_t           period
);

  logic [fpd_pkg::TIME_WIDTH-1:0]   previous_capture;
  logic [fpd_pkg::PERIOD_WIDTH-1:0] last_period;
  logic [fpd_pkg::PERIOD_WIDTH-1:0] cap_ext;
  logic [fpd_pkg::PERIOD_WIDTH-1:0] prev_ext;
  logic [fpd_pkg::PERIOD_WIDTH-1:0] mod_ext;
  logic [fpd_pkg::PERIOD_WIDTH-1:0] period_next;

  assign cap_ext  = {1'b0, capture_time};
  assign prev_ext = {1'b0, previous_capture};
  assign mod_ext  = {1'b0, counter_modulus};

  // wrapped case goes negative when the modulus is smaller than the gap
  // (out of range captures); keep low bits only
  always_comb begin
    if (capture_time >= previous_capture) begin
      period_next = cap_ext - prev_ext;
    end else begin
      period_next = mod_ext + cap_ext - prev_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_capture <= '0;
      last_period      <= '0;
    end else if (capture) begin
      previous_capture <= capture_time;
      last_period      <= period_next;
    end
  end

  assign period.period_next = period_next;
  assign period.last_period = last_period;

endmodule

// ===== hw/rtl/fpd_framer.sv =====
// Start detection, bit sampling and odd parity check for one serial byte.
// Depends on fpd_pkg.
module fpd_framer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          command,
  input  fpd_pkg::fpd_period_t          period,
  input  logic [fpd_pkg::TIME_WIDTH-1:0] tone_threshold,
  input  logic [fpd_pkg::TIME_WIDTH-1:0] min_start_period,
  output fpd_pkg::fpd_result_t          result
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_READ  = 2'd2;
  localparam logic [1:0] PH_CHECK = 2'd3;

  logic [1:0]                           phase;
  logic [1:0]                           phase_next;
  logic                                 wait_count;
  logic                                 wait_count_next;
  logic [fpd_pkg::DATA_BITS-1:0]        shift_byte;
  logic [fpd_pkg::DATA_BITS-1:0]        shift_byte_next;
  logic [fpd_pkg::BIT_INDEX_WIDTH-1:0]  bit_index;
  logic [fpd_pkg::BIT_INDEX_WIDTH-1:0]  bit_index_next;
  logic                                 parity_bit;
  logic                                 parity_bit_next;
  logic [fpd_pkg::PERIOD_WIDTH-1:0]     thr_ext;
  logic [fpd_pkg::PERIOD_WIDTH-1:0]     min_ext;
  logic                                 start_tone;
  logic                                 sample;
  logic                                 data_done;

  assign thr_ext    = {1'b0, tone_threshold};
  assign min_ext    = {1'b0, min_start_period};
  assign start_tone = (period.period_next < thr_ext) && (period.period_next > min_ext);
  assign sample     = period.last_period > thr_ext;
  assign data_done  = bit_index >= fpd_pkg::BIT_INDEX_WIDTH'(fpd_pkg::DATA_BITS);

  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    shift_byte_next = shift_byte;
    bit_index_next  = bit_index;
    parity_bit_next = parity_bit;
    result.valid    = 1'b0;
    result.data     = fpd_pkg::OUT_WIDTH'(shift_byte);
    if (command == fpd_pkg::CMD_CAPTURE) begin
      unique case (phase)
        PH_IDLE: begin
          if (start_tone) begin
            phase_next = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (wait_count) begin
            wait_count_next = 1'b0;
            phase_next      = PH_READ;
          end else begin
            wait_count_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else begin
      unique case (phase)
        PH_READ: begin
          if (data_done) begin
            parity_bit_next = sample;
            bit_index_next  = '0;
            phase_next      = PH_CHECK;
          end else begin
            // MSB first: bit k lands at DATA_BITS-1-k
            for (int i = 0; i < fpd_pkg::DATA_BITS; i++) begin
              if (bit_index == fpd_pkg::BIT_INDEX_WIDTH'(fpd_pkg::DATA_BITS - 1 - i)) begin
                shift_byte_next[i] = shift_byte[i] | sample;
              end
            end
            bit_index_next = bit_index + 1'b1;
          end
        end
        PH_CHECK: begin
          // odd parity over data plus parity bit
          result.valid    = (^shift_byte) != parity_bit;
          shift_byte_next = '0;
          parity_bit_next = 1'b0;
          phase_next      = PH_IDLE;
        end
        default: begin
        end
      endcase
    end
    if (!step) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= 1'b0;
      shift_byte <= '0;
      bit_index  <= '0;
      parity_bit <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      shift_byte <= shift_byte_next;
      bit_index  <= bit_index_next;
      parity_bit <= parity_bit_next;
    end
  end

endmodule

// ===== hw/rtl/fsk_period_demodulator_core.sv =====
// Top level of the FSK period demodulator: input register, configuration
// registers, period unit, framer and output register.
// Depends on fpd_pkg, fpd_period, fpd_framer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  input    | in_valid / in_ready   | command, capture_time
//  output   | out_valid / out_ready | data_byte
//  config   | cfg_write             | cfg_index, cfg_data
//
// One item per cycle sustained unless the output stalls. An accepted item waits
// in the input register until it moves on; out_valid rises as the tick that
// completes the parity check moves from the input to the output register.
// in_ready drops only while the input register holds an item and the output
// register holds a byte that out_ready has not taken.
// rst (synchronous, active high) empties both registers, sets the framer
// idle, clears the stored capture and period, and loads register defaults.
module fsk_period_demodulator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [fpd_pkg::TIME_WIDTH-1:0]      capture_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fpd_pkg::OUT_WIDTH-1:0]       data_byte,
  input  logic                                cfg_write,
  input  logic [fpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fpd_pkg::CFG_WIDTH-1:0]       cfg_data
);

  fpd_pkg::fpd_cfg_t    cfg;
  fpd_pkg::fpd_item_t   item;
  fpd_pkg::fpd_period_t period;
  fpd_pkg::fpd_result_t result;
  logic                 item_valid;
  logic                 step;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counter_modulus  <= fpd_pkg::RST_COUNTER_MODULUS;
      cfg.tone_threshold   <= fpd_pkg::RST_TONE_THRESHOLD;
      cfg.min_start_period <= fpd_pkg::RST_MIN_START_PERIOD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fpd_pkg::CFG_COUNTER_MODULUS:  cfg.counter_modulus  <= cfg_data;
        fpd_pkg::CFG_TONE_THRESHOLD:   cfg.tone_threshold   <= cfg_data;
        fpd_pkg::CFG_MIN_START_PERIOD: cfg.min_start_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Held item moves on whenever the output register is free or being drained
  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.command      <= command;
      item.capture_time <= capture_time;
    end
  end

  fpd_period u_period (
    .clk             (clk),
    .rst             (rst),
    .capture         (step && (item.command == fpd_pkg::CMD_CAPTURE)),
    .capture_time    (item.capture_time),
    .counter_modulus (cfg.counter_modulus),
    .period          (period)
  );

  fpd_framer u_framer (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .command          (item.command),
    .period           (period),
    .tone_threshold   (cfg.tone_threshold),
    .min_start_period (cfg.min_start_period),
    .result           (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      data_byte <= result.data;
    end
  end

endmodule

// ===== hw/rtl/fpd_checker.sv =====
// Port-level checks for the FSK period demodulator, bound to the top level.
// Depends on fpd_pkg and fsk_period_demodulator_core.
module fpd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           command,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fpd_pkg::OUT_WIDTH-1:0]  data_byte
);

  // Output register is empty right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A held byte stays put until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte))
    else $error("stalled byte changed");

  // Input side stalls only behind a stalled output
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output back-pressure");

  // A fresh byte comes from a tick item accepted earlier
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (command == fpd_pkg::CMD_TICK), 2))
    else $error("byte without a preceding tick item");

endmodule

bind fsk_period_demodulator_core fpd_checker u_fpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .command   (command),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .data_byte (data_byte)
);
